// File: hw/rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// types, constants and helper functions of the sensorless six-step commutator
// ----------------------------------------------------------------------------
package sbc_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DUTY_MIN         = 3'd0,
		REG_DUTY_MAX         = 3'd1,
		REG_START_DUTY       = 3'd2,
		REG_SPEED_INCREMENT  = 3'd3,
		REG_FIRST_PERIOD     = 3'd4,
		REG_PERIOD_DECREMENT = 3'd5,
		REG_STEPS_PER_STAGE  = 3'd6,
		REG_DEBOUNCE_SAMPLES = 3'd7
	} cfg_reg_t;

	localparam logic [7:0] RST_DUTY_MIN         = 8'd15;
	localparam logic [7:0] RST_DUTY_MAX         = 8'd250;
	localparam logic [7:0] RST_START_DUTY       = 8'd150;
	localparam logic [7:0] RST_SPEED_INCREMENT  = 8'd5;
	localparam logic [7:0] RST_FIRST_PERIOD     = 8'd22;
	localparam logic [7:0] RST_PERIOD_DECREMENT = 8'd3;
	localparam logic [7:0] RST_STEPS_PER_STAGE  = 8'd30;
	localparam logic [5:0] RST_DEBOUNCE_SAMPLES = 6'd10;

	localparam logic [6:0] REPEAT_MS      = 7'd100;
	localparam logic [5:0] DEBOUNCE_LIMIT = 6'd63;
	localparam logic [2:0] LAST_STEP      = 3'd5;

	localparam logic [1:0] PHASE_A    = 2'd0;
	localparam logic [1:0] PHASE_B    = 2'd1;
	localparam logic [1:0] PHASE_C    = 2'd2;
	localparam logic [1:0] PHASE_NONE = 2'd3;

	typedef struct packed {
		logic [7:0] duty_min;
		logic [7:0] duty_max;
		logic [7:0] start_duty;
		logic [7:0] speed_increment;
		logic [7:0] first_period_ms;
		logic [7:0] period_decrement_ms;
		logic [7:0] steps_per_stage;
		logic [5:0] debounce_samples;
	} cfg_t;

	typedef struct packed {
		logic comp_level;
		logic ms_tick;
		logic up_pressed;
		logic down_pressed;
	} in_item_t;

	typedef struct packed {
		logic [1:0] high_phase;
		logic [1:0] low_phase;
		logic [7:0] pwm_duty;
		logic [1:0] sense_phase;
		logic       sense_rising;
		logic       closed_loop;
		logic       commutated;
	} out_item_t;

	function automatic logic [7:0] clamp_duty(input logic signed [9:0] d,
			input logic [7:0] lo, input logic [7:0] hi);
		logic signed [9:0] r;
		r = d;
		if (r < $signed({2'b00, lo})) r = $signed({2'b00, lo});
		if (r > $signed({2'b00, hi})) r = $signed({2'b00, hi});
		return r[7:0];
	endfunction

	function automatic logic [1:0] step_high(input logic [2:0] s);
		logic [1:0] p;
		case (s)
			3'd0, 3'd1: p = PHASE_A;
			3'd2, 3'd3: p = PHASE_B;
			3'd4, 3'd5: p = PHASE_C;
			default:    p = PHASE_NONE;
		endcase
		return p;
	endfunction

	function automatic logic [1:0] step_low(input logic [2:0] s);
		logic [1:0] p;
		case (s)
			3'd0, 3'd5: p = PHASE_B;
			3'd1, 3'd2: p = PHASE_C;
			3'd3, 3'd4: p = PHASE_A;
			default:    p = PHASE_NONE;
		endcase
		return p;
	endfunction

	function automatic logic [1:0] step_sense(input logic [2:0] s);
		logic [1:0] p;
		case (s)
			3'd0, 3'd3: p = PHASE_C;
			3'd1, 3'd4: p = PHASE_B;
			default:    p = PHASE_A;
		endcase
		return p;
	endfunction

endpackage

// File: hw/rtl/sbc_if.sv
// ----------------------------------------------------------------------------
// sbc_in_if / sbc_out_if
// valid/ready channels for comparator samples and commutation results
// ----------------------------------------------------------------------------
interface sbc_in_if;
	logic valid;
	logic ready;
	logic comp_level;
	logic ms_tick;
	logic up_pressed;
	logic down_pressed;

	modport source (output valid, comp_level, ms_tick, up_pressed, down_pressed,
		input ready);
	modport sink (input valid, comp_level, ms_tick, up_pressed, down_pressed,
		output ready);
endinterface

interface sbc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] high_phase;
	logic [1:0] low_phase;
	logic [7:0] pwm_duty;
	logic [1:0] sense_phase;
	logic       sense_rising;
	logic       closed_loop;
	logic       commutated;

	modport source (output valid, high_phase, low_phase, pwm_duty, sense_phase,
		sense_rising, closed_loop, commutated, input ready);
	modport sink (input valid, high_phase, low_phase, pwm_duty, sense_phase,
		sense_rising, closed_loop, commutated, output ready);
endinterface

// File: hw/rtl/sbc_cfg_regs.sv
// ----------------------------------------------------------------------------
// sbc_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module sbc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [sbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sbc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output sbc_pkg::cfg_t                   cfg
);
	import sbc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_min            <= RST_DUTY_MIN;
			cfg_q.duty_max            <= RST_DUTY_MAX;
			cfg_q.start_duty          <= RST_START_DUTY;
			cfg_q.speed_increment     <= RST_SPEED_INCREMENT;
			cfg_q.first_period_ms     <= RST_FIRST_PERIOD;
			cfg_q.period_decrement_ms <= RST_PERIOD_DECREMENT;
			cfg_q.steps_per_stage     <= RST_STEPS_PER_STAGE;
			cfg_q.debounce_samples    <= RST_DEBOUNCE_SAMPLES;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_DUTY_MIN:         cfg_q.duty_min            <= cfg_data;
				REG_DUTY_MAX:         cfg_q.duty_max            <= cfg_data;
				REG_START_DUTY:       cfg_q.start_duty          <= cfg_data;
				REG_SPEED_INCREMENT:  cfg_q.speed_increment     <= cfg_data;
				REG_FIRST_PERIOD:     cfg_q.first_period_ms     <= cfg_data;
				REG_PERIOD_DECREMENT: cfg_q.period_decrement_ms <= cfg_data;
				REG_STEPS_PER_STAGE:  cfg_q.steps_per_stage     <= cfg_data;
				REG_DEBOUNCE_SAMPLES: cfg_q.debounce_samples    <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/sbc_core.sv
// ----------------------------------------------------------------------------
// sbc_core
// commutation state: open-loop ramp, back-emf debounce and duty buttons
// ----------------------------------------------------------------------------
module sbc_core #(
	parameter int START_STAGES = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  sbc_pkg::cfg_t       cfg,
	input  sbc_pkg::in_item_t   item,
	output sbc_pkg::out_item_t  result
);
	import sbc_pkg::*;

	localparam int STAGE_W = $clog2(START_STAGES + 1);
	localparam int DEC_W = STAGE_W + 8;

	logic [2:0]         next_step_q, next_step_d;
	logic [2:0]         applied_q, applied_d;
	logic               drive_valid_q, drive_valid_d;
	logic [7:0]         duty_q, duty_d;
	logic [STAGE_W-1:0] stage_q, stage_d;
	logic [7:0]         stage_cnt_q, stage_cnt_d;
	logic [7:0]         period_q, period_d;
	logic               deb_active_q, deb_active_d;
	logic [5:0]         deb_cnt_q, deb_cnt_d;
	logic               prev_level_q;
	logic [6:0]         btn_timer_q, btn_timer_d;

	logic               open_loop;
	logic               did;
	logic               want;
	logic [5:0]         need;
	logic [DEC_W-1:0]   dec;
	logic [DEC_W-1:0]   first_w;
	logic [7:0]         stage_period;
	logic [7:0]         stage_cnt_inc;
	logic [6:0]         btn_timer_dn;

	assign open_loop = stage_q < STAGE_W'(START_STAGES);
	assign dec = DEC_W'(stage_q) * DEC_W'(cfg.period_decrement_ms);
	assign first_w = DEC_W'(cfg.first_period_ms);
	assign stage_period = (first_w > dec) ? 8'(first_w - dec) : 8'd1;
	assign stage_cnt_inc = stage_cnt_q + 8'd1;
	assign need = (cfg.debounce_samples == 6'd0) ? 6'd1 : cfg.debounce_samples;
	assign want = next_step_q[0];
	assign btn_timer_dn = (item.ms_tick && btn_timer_q != 7'd0) ?
		btn_timer_q - 7'd1 : btn_timer_q;

	always_comb begin
		next_step_d   = next_step_q;
		applied_d     = applied_q;
		drive_valid_d = drive_valid_q;
		duty_d        = duty_q;
		stage_d       = stage_q;
		stage_cnt_d   = stage_cnt_q;
		period_d      = period_q;
		deb_active_d  = deb_active_q;
		deb_cnt_d     = deb_cnt_q;
		btn_timer_d   = btn_timer_q;
		did           = 1'b0;

		if (open_loop) begin
			duty_d = clamp_duty($signed({2'b00, cfg.start_duty}), cfg.duty_min, cfg.duty_max);
			if (period_q == 8'd0) begin
				did = 1'b1;
				period_d = stage_period;
			end else if (item.ms_tick) begin
				period_d = period_q - 8'd1;
				if (period_q == 8'd1) begin
					if (stage_cnt_inc >= cfg.steps_per_stage) begin
						stage_cnt_d = 8'd0;
						stage_d = stage_q + STAGE_W'(1);
					end else begin
						stage_cnt_d = stage_cnt_inc;
					end
				end
			end
		end else begin
			if (!deb_active_q) begin
				if (item.comp_level != prev_level_q && item.comp_level == want) begin
					deb_active_d = 1'b1;
					deb_cnt_d = 6'd1;
				end
			end else if (item.comp_level == want && deb_cnt_q < DEBOUNCE_LIMIT) begin
				deb_cnt_d = deb_cnt_q + 6'd1;
			end
			if (deb_active_d && deb_cnt_d >= need) begin
				did = 1'b1;
				deb_active_d = 1'b0;
				deb_cnt_d = 6'd0;
			end

			btn_timer_d = btn_timer_dn;
			if (btn_timer_dn == 7'd0) begin
				if (item.up_pressed) begin
					if (duty_q < cfg.duty_max) begin
						duty_d = clamp_duty($signed({2'b00, duty_q}) +
							$signed({2'b00, cfg.speed_increment}), cfg.duty_min, cfg.duty_max);
						btn_timer_d = REPEAT_MS;
					end
				end else if (item.down_pressed) begin
					if (duty_q > cfg.duty_min) begin
						duty_d = clamp_duty($signed({2'b00, duty_q}) -
							$signed({2'b00, cfg.speed_increment}), cfg.duty_min, cfg.duty_max);
						btn_timer_d = REPEAT_MS;
					end
				end
			end
		end

		if (did) begin
			applied_d = next_step_q;
			drive_valid_d = 1'b1;
			next_step_d = (next_step_q >= LAST_STEP) ? 3'd0 : next_step_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_step_q   <= 3'd0;
			applied_q     <= 3'd0;
			drive_valid_q <= 1'b0;
			duty_q        <= RST_START_DUTY;
			stage_q       <= '0;
			stage_cnt_q   <= 8'd0;
			period_q      <= 8'd0;
			deb_active_q  <= 1'b0;
			deb_cnt_q     <= 6'd0;
			prev_level_q  <= 1'b0;
			btn_timer_q   <= 7'd0;
		end else if (take) begin
			next_step_q   <= next_step_d;
			applied_q     <= applied_d;
			drive_valid_q <= drive_valid_d;
			duty_q        <= duty_d;
			stage_q       <= stage_d;
			stage_cnt_q   <= stage_cnt_d;
			period_q      <= period_d;
			deb_active_q  <= deb_active_d;
			deb_cnt_q     <= deb_cnt_d;
			prev_level_q  <= item.comp_level;
			btn_timer_q   <= btn_timer_d;
		end
	end

	always_comb begin
		if (drive_valid_d) begin
			result.high_phase   = step_high(applied_d);
			result.low_phase    = step_low(applied_d);
			result.sense_phase  = step_sense(applied_d);
			result.sense_rising = ~applied_d[0];
		end else begin
			result.high_phase   = PHASE_NONE;
			result.low_phase    = PHASE_NONE;
			result.sense_phase  = PHASE_A;
			result.sense_rising = 1'b0;
		end
		result.pwm_duty    = duty_d;
		result.closed_loop = !(stage_d < STAGE_W'(START_STAGES));
		result.commutated  = did;
	end

endmodule

// File: hw/rtl/sensorless_bldc_commutator_unit.sv
// ----------------------------------------------------------------------------
// sensorless_bldc_commutator_unit
// six-step sensorless commutator, one comparator/tick/button request per item
// ----------------------------------------------------------------------------
// path: an accepted request passes the input register, then the result register, before its result is valid
// throughput: one request per cycle while the result is not stalled, set by the state update in sbc_core
// a stalled result still lets the input register take one more request
// reset: asynchronous, clears pipeline and commutation state, registers take defaults
module sensorless_bldc_commutator_unit #(
	parameter int START_STAGES = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sbc_in_if.sink                          sample,
	sbc_out_if.source                       drive,
	input  logic                            cfg_wr_en,
	input  logic [sbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sbc_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t res_s2;
	logic      valid_s2;
	logic      move_s2;
	logic      adv_s1;
	logic      take_in;

	assign move_s2 = !valid_s2 || drive.ready;
	assign adv_s1 = valid_s1 && move_s2;
	assign sample.ready = !valid_s1 || move_s2;
	assign take_in = sample.valid && sample.ready;

	sbc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sbc_core #(.START_STAGES(START_STAGES)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (adv_s1),
		.cfg    (cfg),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample.ready) valid_s1 <= sample.valid;
			if (move_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.comp_level   <= sample.comp_level;
			item_s1.ms_tick      <= sample.ms_tick;
			item_s1.up_pressed   <= sample.up_pressed;
			item_s1.down_pressed <= sample.down_pressed;
		end
		if (adv_s1) res_s2 <= result;
	end

	assign drive.valid        = valid_s2;
	assign drive.high_phase   = res_s2.high_phase;
	assign drive.low_phase    = res_s2.low_phase;
	assign drive.pwm_duty     = res_s2.pwm_duty;
	assign drive.sense_phase  = res_s2.sense_phase;
	assign drive.sense_rising = res_s2.sense_rising;
	assign drive.closed_loop  = res_s2.closed_loop;
	assign drive.commutated   = res_s2.commutated;

endmodule

// File: hw/rtl/sbc_checker.sv
// ----------------------------------------------------------------------------
// sbc_checker
// port-level checks of the commutator, attached to the top level by bind
// ----------------------------------------------------------------------------
module sbc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] high_phase,
	input logic [1:0] low_phase,
	input logic [7:0] pwm_duty,
	input logic       closed_loop,
	input logic       commutated
);
	logic [1:0] pending_q;
	logic       closed_seen_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			closed_seen_q <= 1'b0;
		end else begin
			pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
			if (out_acc) closed_seen_q <= closed_loop;
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({high_phase, low_phase, pwm_duty,
			closed_loop, commutated}))
		else $error("result changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result without request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more requests in flight than pipeline stages");

	a_loop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && closed_seen_q |-> closed_loop)
		else $error("closed loop left after start-up");

endmodule

bind sensorless_bldc_commutator_unit sbc_checker u_sbc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.out_valid   (drive.valid),
	.out_ready   (drive.ready),
	.high_phase  (drive.high_phase),
	.low_phase   (drive.low_phase),
	.pwm_duty    (drive.pwm_duty),
	.closed_loop (drive.closed_loop),
	.commutated  (drive.commutated)
);
